>>> sv/assert_macros.svh
// Assertion macros shared by the predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, but also checked while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ghbp_pkg.sv
// Shared widths and parameter defaults for the global history branch predictor.
`default_nettype none
package ghbp_pkg;
	localparam int HISTORY_BITS_DEF = 4;
	localparam int ADDRESS_BITS_DEF = 8;
	localparam int COUNTER_BITS_DEF = 2;

	localparam int ADDR_W = 32;
	localparam int STAT_W = 32;
	localparam int USED_W = 13;
endpackage
`default_nettype wire

>>> sv/ghbp_branch_if.sv
// Branch item channel: address and resolved outcome.
`default_nettype none
interface ghbp_branch_if;
	import ghbp_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] branch_address;
	logic              actual_taken;

	modport source (output valid, output branch_address, output actual_taken, input ready);
	modport sink (input valid, input branch_address, input actual_taken, output ready);
endinterface
`default_nettype wire

>>> sv/ghbp_result_if.sv
// Result item channel: prediction and running statistics.
`default_nettype none
interface ghbp_result_if;
	import ghbp_pkg::*;
	logic              valid;
	logic              ready;
	logic              predicted_taken;
	logic [STAT_W-1:0] correct_count;
	logic [STAT_W-1:0] total_count;
	logic [USED_W-1:0] used_entries;

	modport source (output valid, output predicted_taken, output correct_count,
		output total_count, output used_entries, input ready);
	modport sink (input valid, input predicted_taken, input correct_count,
		input total_count, input used_entries, output ready);
endinterface
`default_nettype wire

>>> sv/ghbp_table.sv
// Counter/mark table memory with a clearing sweep after reset.
`default_nettype none
module ghbp_table #(
	parameter int IDX_W  = 12,
	parameter int DATA_W = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_addr,
	output      logic [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	output      logic              busy
);
	localparam int DEPTH = 1 << IDX_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              clr_q;
	logic [IDX_W-1:0]  clr_addr_q;
	logic              we;
	logic [IDX_W-1:0]  wa;
	logic [DATA_W-1:0] wd;

	// one entry zeroed per cycle until the whole table has been swept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == '1) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + IDX_W'(1);
		end
	end

	always_comb begin
		we = clr_q | wr_en;
		wa = clr_q ? clr_addr_q : wr_addr;
		wd = clr_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_q;
endmodule
`default_nettype wire

>>> sv/ghbp_update.sv
// Saturating counter update and prediction for one table entry.
`default_nettype none
module ghbp_update #(
	parameter int COUNTER_BITS = 2
) (
	input  wire logic [COUNTER_BITS-1:0] cnt,
	input  wire logic                    taken,
	output      logic [COUNTER_BITS-1:0] cnt_next,
	output      logic                    predicted
);
	localparam logic [COUNTER_BITS-1:0] CNT_HALF =
		COUNTER_BITS'(1) << (COUNTER_BITS - 1);
	localparam logic [COUNTER_BITS-1:0] CNT_HALF_M1 = CNT_HALF - COUNTER_BITS'(1);
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	assign predicted = cnt >= CNT_HALF;

	// crossing the threshold in the outcome's direction jumps to the end
	always_comb begin
		cnt_next = cnt;
		if (taken) begin
			if (cnt == CNT_HALF_M1) begin
				cnt_next = CNT_MAX;
			end else if (cnt != CNT_MAX) begin
				cnt_next = cnt + COUNTER_BITS'(1);
			end
		end else begin
			if (cnt == CNT_HALF) begin
				cnt_next = '0;
			end else if (cnt != '0) begin
				cnt_next = cnt - COUNTER_BITS'(1);
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/global_history_branch_predictor_unit.sv
// Results are registered: the table read is registered at accept, and the result
// register loads at write-back. A new branch item is not accepted until the last
// one has written back, and a held result stalls the next write-back.
// Reset: arst_n clears history and statistics, then the table is swept to zero,
// one entry per cycle over all 2^(ADDRESS_BITS+HISTORY_BITS) entries (4096 by default),
// with branch ready held low during the sweep.
`default_nettype none
`include "assert_macros.svh"
module global_history_branch_predictor_unit #(
	parameter int HISTORY_BITS = ghbp_pkg::HISTORY_BITS_DEF,
	parameter int ADDRESS_BITS = ghbp_pkg::ADDRESS_BITS_DEF,
	parameter int COUNTER_BITS = ghbp_pkg::COUNTER_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	ghbp_branch_if.sink branch,
	ghbp_result_if.source result
);
	import ghbp_pkg::*;

	localparam int IDX_W  = ADDRESS_BITS + HISTORY_BITS;
	localparam int DATA_W = COUNTER_BITS + 1;

	logic [IDX_W-1:0]        idx;
	logic                    accept;
	logic                    tbl_busy;
	logic [DATA_W-1:0]       rd_data;
	logic [DATA_W-1:0]       wr_data;
	logic                    pend_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    taken_s1;
	logic                    s1_fire;
	logic [COUNTER_BITS-1:0] cnt_next;
	logic                    predicted;
	logic                    out_valid_q;
	logic                    pred_q;
	logic [STAT_W-1:0]       hits_q;
	logic [STAT_W-1:0]       branches_q;
	logic [USED_W-1:0]       touched_q;

	assign branch.ready = !tbl_busy && !pend_s1;
	assign accept       = branch.valid && branch.ready;

	generate
		if (HISTORY_BITS > 0) begin : g_hist
			logic [HISTORY_BITS-1:0] hist_q;

			// history moves at accept so the next index is ready at once
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hist_q <= '0;
				end else if (accept) begin
					hist_q <= HISTORY_BITS'({hist_q, branch.actual_taken});
				end
			end

			assign idx = {branch.branch_address[ADDRESS_BITS-1:0], hist_q};
		end else begin : g_nohist
			assign idx = branch.branch_address[ADDRESS_BITS-1:0];
		end
	endgenerate

	ghbp_table #(
		.IDX_W  (IDX_W),
		.DATA_W (DATA_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (idx),
		.rd_data (rd_data),
		.wr_en   (s1_fire),
		.wr_addr (idx_s1),
		.wr_data (wr_data),
		.busy    (tbl_busy)
	);

	ghbp_update #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_update (
		.cnt       (rd_data[COUNTER_BITS-1:0]),
		.taken     (taken_s1),
		.cnt_next  (cnt_next),
		.predicted (predicted)
	);

	// entry word: used mark on top, counter below
	assign wr_data = {1'b1, cnt_next};
	assign s1_fire = pend_s1 && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (accept) begin
			pend_s1 <= 1'b1;
		end else if (s1_fire) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= idx;
			taken_s1 <= branch.actual_taken;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			branches_q  <= '0;
			touched_q   <= '0;
		end else begin
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				hits_q      <= hits_q + STAT_W'(predicted == taken_s1);
				branches_q  <= branches_q + STAT_W'(1);
				touched_q   <= touched_q + USED_W'(!rd_data[DATA_W-1]);
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			pred_q <= predicted;
		end
	end

	// statistics only move on a write-back, which waits for the result slot
	assign result.valid           = out_valid_q;
	assign result.predicted_taken = pred_q;
	assign result.correct_count   = hits_q;
	assign result.total_count     = branches_q;
	assign result.used_entries    = touched_q;

	`ASSERT_CLK(a_accept_loads_s1, accept |=> pend_s1, "accepted item did not enter s1")
	`ASSERT_CLK(a_no_accept_in_sweep, tbl_busy |-> !accept, "item accepted during sweep")
	`ASSERT_CLK(a_total_steps, s1_fire |=> branches_q == $past(branches_q) + STAT_W'(1), "no step")
	`ASSERT_CLK(a_used_steps, s1_fire |=> (touched_q - $past(touched_q)) <= USED_W'(1), "used jump")
endmodule
`default_nettype wire

>>> test/ghbp_checker.sv
// Checker for the branch predictor: tracks the predictor state and compares every result item.
`default_nettype none
module ghbp_checker (
	input wire logic clk,
	input wire logic arst_n,
	ghbp_branch_if   branch,
	ghbp_result_if   result,
	output int       fail_count,
	output int       pending
);
	import ghbp_pkg::*;

	localparam int HB    = HISTORY_BITS_DEF;
	localparam int AB    = ADDRESS_BITS_DEF;
	localparam int CB    = COUNTER_BITS_DEF;
	localparam int IDX_W = AB + HB;
	localparam int DEPTH = 1 << IDX_W;

	localparam logic [CB-1:0] CTR_MAX  = '1;
	localparam logic [CB-1:0] CTR_HALF = CB'(1) << (CB - 1);

	typedef struct packed {
		logic              predicted_taken;
		logic [STAT_W-1:0] correct_count;
		logic [STAT_W-1:0] total_count;
		logic [USED_W-1:0] used_entries;
	} prediction_t;

	logic [CB-1:0]     ctr_tbl [DEPTH];
	logic              used_mark [DEPTH];
	logic [HB-1:0]     history;
	logic [STAT_W-1:0] hit_cnt;
	logic [STAT_W-1:0] branch_cnt;
	logic [USED_W-1:0] touched_cnt;
	prediction_t       predictions_q [$];
	int                errors;

	// Weak states jump across to the strong state of the other side.
	function automatic logic [CB-1:0] step_counter(input logic [CB-1:0] c, input logic taken);
		if (taken) begin
			if (c == CTR_HALF - 1'b1)
				return CTR_MAX;
			return (c == CTR_MAX) ? c : c + 1'b1;
		end
		if (c == CTR_HALF)
			return '0;
		return (c == '0) ? c : c - 1'b1;
	endfunction

	task automatic predict_branch(input logic [ADDR_W-1:0] addr, input logic taken,
			output prediction_t p);
		logic [IDX_W-1:0] idx;
		logic             guess;
		idx = {addr[AB-1:0], history};
		if (!used_mark[idx]) begin
			used_mark[idx] = 1'b1;
			touched_cnt = touched_cnt + 1'b1;
		end
		guess = ctr_tbl[idx] >= CTR_HALF;
		ctr_tbl[idx] = step_counter(ctr_tbl[idx], taken);
		history = HB'({history, taken});
		if (guess == taken)
			hit_cnt = hit_cnt + 1'b1;
		branch_cnt = branch_cnt + 1'b1;
		p.predicted_taken = guess;
		p.correct_count   = hit_cnt;
		p.total_count     = branch_cnt;
		p.used_entries    = touched_cnt;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		prediction_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				ctr_tbl[i]   = '0;
				used_mark[i] = 1'b0;
			end
			history     = '0;
			hit_cnt     = '0;
			branch_cnt  = '0;
			touched_cnt = '0;
			errors      = 0;
			predictions_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (predictions_q.size() == 0) begin
					$display("%0t: result item with nothing expected, expected none, actual %0h %0h %0h %0h",
						$time, result.predicted_taken, result.correct_count,
						result.total_count, result.used_entries);
					errors++;
				end else begin
					want = predictions_q.pop_front();
					check_field("predicted_taken", 32'(want.predicted_taken), 32'(result.predicted_taken));
					check_field("correct_count", want.correct_count, result.correct_count);
					check_field("total_count", want.total_count, result.total_count);
					check_field("used_entries", 32'(want.used_entries), 32'(result.used_entries));
				end
			end
			if (branch.valid && branch.ready) begin
				predict_branch(branch.branch_address, branch.actual_taken, want);
				predictions_q.push_back(want);
			end
			pending    <= predictions_q.size();
			fail_count <= errors;
		end
	end
endmodule
`default_nettype wire

>>> test/testbench.sv
// Top of the predictor testbench: clock, reset, branch stimulus, result back-pressure, verdict.
`default_nettype none
module testbench;
	import ghbp_pkg::*;

	localparam int AB             = ADDRESS_BITS_DEF;
	localparam int POOL           = 6;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic calm;
	logic hold_req;
	int   fails;
	int   pending;
	int   quiet_cycles;

	ghbp_branch_if branch_ch ();
	ghbp_result_if result_ch ();

	global_history_branch_predictor_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.branch (branch_ch),
		.result (result_ch)
	);

	ghbp_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.branch     (branch_ch),
		.result     (result_ch),
		.fail_count (fails),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ends the run when nothing moves on either channel for too long.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((branch_ch.valid && branch_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
		while (!calm && $urandom_range(99) < 31) begin
			branch_ch.valid <= 1'b0;
			@(posedge clk);
		end
		branch_ch.valid          <= 1'b1;
		branch_ch.branch_address <= addr;
		branch_ch.actual_taken   <= taken;
		@(posedge clk);
		while (!branch_ch.ready)
			@(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		bit held;
		result_ch.ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ch.ready <= calm || ($urandom_range(99) >= 31);
		end
	end

	initial begin
		logic [AB-1:0]     pool_lo [POOL];
		int                bias [POOL];
		logic [ADDR_W-1:0] addr;
		logic              taken;
		int                k;
		branch_ch.valid          = 1'b0;
		branch_ch.branch_address = '0;
		branch_ch.actual_taken   = 1'b0;
		calm     = 1'b0;
		hold_req = 1'b0;
		arst_n   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// One slot walked through its states: with all-taken history the same entry
		// comes back, weak not-taken jumps to strong taken, weak taken drops to zero.
		repeat (7) send_branch('0, 1'b1);
		send_branch('0, 1'b0);
		repeat (4) send_branch('0, 1'b1);
		send_branch('0, 1'b0);
		repeat (5) send_branch('0, 1'b1);
		// address extremes; upper bits must not matter
		send_branch(32'hFFFF_FFFF, 1'b1);
		send_branch(32'hFFFF_FF00, 1'b0);
		send_branch(32'h0000_00FF, 1'b0);
		send_branch(32'h8000_0001, 1'b1);
		send_branch(32'h5555_5555, 1'b0);
		send_branch(32'hAAAA_AAAA, 1'b1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// hot branches with a per-branch bias keep revisiting the same entries
			if (n % 250 == 0) begin
				for (int j = 0; j < POOL; j++) begin
					pool_lo[j] = AB'($urandom());
					case ($urandom_range(4))
						0: bias[j] = 0;
						1: bias[j] = 10;
						2: bias[j] = 50;
						3: bias[j] = 90;
						default: bias[j] = 100;
					endcase
				end
			end
			calm <= (n >= 200 && n < 400);
			if (n == 500)
				hold_req <= 1'b1;
			if (n == 700) begin
				branch_ch.valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			addr = $urandom();
			if ($urandom_range(99) < 70) begin
				k = $urandom_range(POOL - 1);
				addr[AB-1:0] = pool_lo[k];
				taken = ($urandom_range(99) < bias[k]);
			end else begin
				taken = 1'($urandom_range(1));
			end
			send_branch(addr, taken);
		end

		branch_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
+incdir+sv
sv/ghbp_pkg.sv
sv/ghbp_branch_if.sv
sv/ghbp_result_if.sv
sv/ghbp_table.sv
sv/ghbp_update.sv
sv/global_history_branch_predictor_unit.sv
test/ghbp_checker.sv
test/testbench.sv
